// ----- hdl/pbs_pkg.sv -----
// shared types, constants and the arctangent table for the polygon boundary store
// no dependencies; imported by pbs_cordic, polygon_boundary_store and the testbench

package pbs_pkg;

	localparam int MAX_POINTS_DEF = 64;
	localparam int CORDIC_STEPS_DEF = 14;
	localparam int MIN_POLY = 3;

	localparam logic [2:0] OP_ADD       = 3'd0;
	localparam logic [2:0] OP_REMOVE    = 3'd1;
	localparam logic [2:0] OP_CLEAR     = 3'd2;
	localparam logic [2:0] OP_INSIDE    = 3'd3;
	localparam logic [2:0] OP_DIRECTION = 3'd4;

	localparam logic [15:0] HALF_TURN = 16'h8000;
	localparam logic signed [23:0] MEAN_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] MEAN_MIN = 24'sh800000;

	typedef struct packed {
		logic [2:0]         operation;
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic signed [15:0] pz;
		logic [5:0]         index;
		logic signed [15:0] heading;
	} cmd_t;

	typedef struct packed {
		logic               ok;
		logic               inside_res;
		logic               inwards;
		logic [6:0]         vertex_count;
		logic signed [23:0] z_average;
	} rsp_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
	} vtx_t;

	// binary angle of atan(2^-i), 32768 units to a half turn
	function automatic logic [15:0] atan_ent(input logic [4:0] i);
		logic [15:0] r;
		case (i)
			5'd0:  r = 16'd8192;
			5'd1:  r = 16'd4836;
			5'd2:  r = 16'd2555;
			5'd3:  r = 16'd1297;
			5'd4:  r = 16'd651;
			5'd5:  r = 16'd326;
			5'd6:  r = 16'd163;
			5'd7:  r = 16'd81;
			5'd8:  r = 16'd41;
			5'd9:  r = 16'd20;
			5'd10: r = 16'd10;
			5'd11: r = 16'd5;
			5'd12: r = 16'd3;
			5'd13: r = 16'd1;
			5'd14: r = 16'd1;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

endpackage

// ----- hdl/polygon_boundary_store.sv -----
// top level of the polygon boundary store: sequencer, vertex memories, output register
// depends on pbs_pkg, pbs_cordic and pbs_div
//
//  channel | direction | handshake             | payload
//  cmd     | in        | cmd_valid / cmd_stall | cmd_t: operation, px, py, pz, index, heading
//  res     | out       | res_valid / res_stall | rsp_t: ok, inside_res, inwards, vertex_count,
//          |           |                       |        z_average
//
// one transaction at a time; cmd_stall stays high until its result sits in the output register
// add: duplicate scan, centroid sums, cordic angles (one step a cycle), selection sort
//   (one angle read a cycle), copy back, mean division; remove: later entries shift down
// inside test: edge by edge, two products per spanning edge; direction test: n+1 angles
// reset clears count and mean; memory contents are not cleared and never read before writing
// a new transaction waits while the previous result is still held back by res_stall

module polygon_boundary_store import pbs_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic res_valid,
	input  logic res_stall,
	output rsp_t res
);

	localparam int AW  = $clog2(MAX_POINTS);
	localparam int CW  = $clog2(MAX_POINTS + 1);
	localparam int SXW = CW + 16;   // sum of all coordinates
	localparam int DW  = CW + 18;   // centroid-scaled offsets
	localparam int NW  = CW + 26;   // mean numerator

	typedef enum logic [4:0] {
		S_IDLE, S_DUP, S_SUM, S_ANG_RD, S_ANG_MUL, S_CRD_GO, S_CRD_WT,
		S_SEL_SCAN, S_SEL_FETCH, S_SEL_PUT, S_COPY, S_MEAN_MUL, S_DIV_GO, S_DIV_WT,
		S_RMV, S_IN_RD, S_IN_EDGE, S_IN_M1, S_IN_M2, S_IN_CMP, S_DR_RD, S_DR_LD, S_DONE
	} state_t;

	state_t state_q;

	// vertex list, angle scratch and sorted scratch
	vtx_t vmem [MAX_POINTS];
	logic signed [15:0] amem [MAX_POINTS];
	vtx_t smem [MAX_POINTS];
	vtx_t vrd_q, srd_q;
	logic signed [15:0] ard_q;

	// held state
	logic [CW-1:0] n_q;
	logic signed [23:0] mean_q;

	// transaction fields
	logic [2:0] op_q;
	logic signed [15:0] px_q, py_q, pz_q, hd_q;

	// sequencer registers
	logic [CW-1:0] i_q, nn_q, k_q;
	logic [AW-1:0] pi_q, best_idx_q;
	logic pv_q, flag_q, first_q, found_q, have_prev_q;
	logic ok_q, ins_q, inw_q;
	logic signed [SXW-1:0] sx_q, sy_q;
	logic signed [DW-1:0] cx_q, cy_q;
	logic signed [15:0] prev_ang_q, best_ang_q, a1_q;
	logic signed [NW-1:0] num_q;
	vtx_t p1_q;
	logic signed [16:0] t1a_q, dyd_q, t2a_q, t2b_q;
	logic signed [33:0] prod1_q, prod2_q;

	rsp_t res_q;
	logic res_valid_q;

	// shared units
	logic crd_done, div_done;
	logic [15:0] crd_angle;
	logic signed [NW-1:0] div_quo;

	// memory ports
	logic [AW-1:0] vr_addr, vw_addr;
	logic vw_en, aw_en, sw_en;
	vtx_t vw_data;

	// scan pipeline
	logic [CW-1:0] scan_lim;
	logic scan_st, scan_more, scan_end;

	// datapath
	logic signed [CW:0] n_sgn, nm1_sgn;
	logic signed [NW-1:0] mnum, qsat;
	logic signed [16:0] ya, yb, xa, xb, ma, mb;
	logic signed [33:0] mp;
	logic signed [34:0] psum;
	logic e_swap, e_flat, e_span, odd_n;
	logic signed [15:0] a2, s_ang, l_ang;
	logic signed [16:0] span;
	logic hit, cand;

	pbs_cordic #(.DW(DW), .STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(state_q == S_CRD_GO),
		.dx(cx_q), .dy(cy_q), .done(crd_done), .angle(crd_angle)
	);

	pbs_div #(.NW(NW), .DVW(CW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(state_q == S_DIV_GO),
		.num(num_q), .den(n_q), .done(div_done), .quo(div_quo)
	);

	// scanning states read one entry a cycle; the data is seen in the cycle after the read
	always_comb begin
		scan_st = 1'b1;
		case (state_q)
			S_DUP, S_RMV: scan_lim = n_q;
			S_SUM, S_SEL_SCAN: scan_lim = nn_q;
			S_COPY: scan_lim = k_q;
			default: begin
				scan_lim = '0;
				scan_st = 1'b0;
			end
		endcase
	end
	assign scan_more = i_q < scan_lim;
	assign scan_end = !scan_more && !pv_q;

	// read address of the vertex memory
	always_comb begin
		case (state_q)
			S_SEL_FETCH: vr_addr = best_idx_q;
			S_IN_RD, S_DR_RD: vr_addr = first_q ? AW'(n_q - CW'(1)) : i_q[AW-1:0];
			default: vr_addr = i_q[AW-1:0];
		endcase
	end

	// write port of the vertex memory: append, copy back, or shift down on remove
	always_comb begin
		vw_en = 1'b0;
		vw_addr = i_q[AW-1:0];
		vw_data = vrd_q;
		case (state_q)
			S_DUP: begin
				vw_en = scan_end && !flag_q;
				vw_addr = n_q[AW-1:0];
				vw_data.x = px_q;
				vw_data.y = py_q;
			end
			S_COPY: begin
				vw_en = pv_q;
				vw_addr = pi_q;
				vw_data = srd_q;
			end
			S_RMV: begin
				vw_en = pv_q;
				vw_addr = pi_q - AW'(1);
			end
			default: vw_en = 1'b0;
		endcase
	end

	assign aw_en = (state_q == S_CRD_WT) && crd_done && (op_q != OP_DIRECTION);
	assign sw_en = state_q == S_SEL_PUT;

	always_ff @(posedge clk) begin
		if (vw_en)
			vmem[vw_addr] <= vw_data;
		vrd_q <= vmem[vr_addr];
	end

	always_ff @(posedge clk) begin
		if (aw_en)
			amem[i_q[AW-1:0]] <= signed'(crd_angle);
		ard_q <= amem[i_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (sw_en)
			smem[k_q[AW-1:0]] <= vrd_q;
		srd_q <= smem[i_q[AW-1:0]];
	end

	// running mean numerator and its saturation
	assign n_sgn = signed'({1'b0, nn_q});
	assign nm1_sgn = signed'({1'b0, n_q - CW'(1)});
	assign mnum = NW'(mean_q) * NW'(nm1_sgn) + (NW'(pz_q) <<< 8);
	always_comb begin
		if (div_quo > NW'(MEAN_MAX))
			qsat = NW'(MEAN_MAX);
		else if (div_quo < NW'(MEAN_MIN))
			qsat = NW'(MEAN_MIN);
		else
			qsat = div_quo;
	end

	// edge ordering for the crossing test, previous vertex against current
	assign e_swap = vrd_q.y < p1_q.y;
	assign ya = e_swap ? 17'(vrd_q.y) : 17'(p1_q.y);
	assign yb = e_swap ? 17'(p1_q.y) : 17'(vrd_q.y);
	assign xa = e_swap ? 17'(vrd_q.x) : 17'(p1_q.x);
	assign xb = e_swap ? 17'(p1_q.x) : 17'(vrd_q.x);
	assign e_flat = vrd_q.y == p1_q.y;
	assign e_span = (17'(py_q) >= ya) && (17'(py_q) < yb);

	// crossing x <= px  <=>  (xa-px)*dy + (xb-xa)*(py-ya) <= 0, one product a cycle
	assign ma = (state_q == S_IN_M2) ? t2a_q : t1a_q;
	assign mb = (state_q == S_IN_M2) ? t2b_q : dyd_q;
	assign mp = 34'(ma) * 34'(mb);
	assign psum = 35'(prod1_q) + 35'(prod2_q);
	assign odd_n = flag_q ^ (psum <= 0);

	// heading against the span of one edge
	assign a2 = signed'(crd_angle);
	assign s_ang = (a1_q < a2) ? a1_q : a2;
	assign l_ang = (a1_q < a2) ? a2 : a1_q;
	assign span = 17'(l_ang) - 17'(s_ang);
	assign hit = (span < 17'sd32768) ? (hd_q >= s_ang && hd_q <= l_ang)
		: (hd_q <= s_ang || hd_q >= l_ang);

	// selection sort: next smallest angle above the last one, later entry wins a tie
	assign cand = (!have_prev_q || ard_q > prev_ang_q) && (!found_q || ard_q <= best_ang_q);

	assign cmd_stall = !(state_q == S_IDLE && (!res_valid_q || !res_stall));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q <= '0;
			mean_q <= '0;
			op_q <= '0;
			px_q <= '0;
			py_q <= '0;
			pz_q <= '0;
			hd_q <= '0;
			i_q <= '0;
			nn_q <= '0;
			k_q <= '0;
			pi_q <= '0;
			best_idx_q <= '0;
			pv_q <= 1'b0;
			flag_q <= 1'b0;
			first_q <= 1'b0;
			found_q <= 1'b0;
			have_prev_q <= 1'b0;
			ok_q <= 1'b0;
			ins_q <= 1'b0;
			inw_q <= 1'b0;
			sx_q <= '0;
			sy_q <= '0;
			cx_q <= '0;
			cy_q <= '0;
			prev_ang_q <= '0;
			best_ang_q <= '0;
			a1_q <= '0;
			num_q <= '0;
			p1_q <= '0;
			t1a_q <= '0;
			dyd_q <= '0;
			t2a_q <= '0;
			t2b_q <= '0;
			prod1_q <= '0;
			prod2_q <= '0;
			res_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall)
				res_valid_q <= 1'b0;

			if (scan_st) begin
				if (scan_more) begin
					pv_q <= 1'b1;
					pi_q <= i_q[AW-1:0];
					i_q <= i_q + CW'(1);
				end else begin
					pv_q <= 1'b0;
				end
			end

			case (state_q)
				S_IDLE: begin
					if (cmd_valid && !cmd_stall) begin
						op_q <= cmd.operation;
						px_q <= cmd.px;
						py_q <= cmd.py;
						pz_q <= cmd.pz;
						hd_q <= cmd.heading;
						ok_q <= 1'b0;
						ins_q <= 1'b0;
						inw_q <= 1'b0;
						flag_q <= 1'b0;
						first_q <= 1'b1;
						i_q <= '0;
						pv_q <= 1'b0;
						case (cmd.operation)
							OP_ADD: state_q <= (n_q >= CW'(MAX_POINTS)) ? S_DONE : S_DUP;
							OP_REMOVE: begin
								if (int'(cmd.index) < int'(n_q)) begin
									i_q <= CW'(int'(cmd.index) + 1);
									state_q <= S_RMV;
								end else begin
									state_q <= S_DONE;
								end
							end
							OP_CLEAR: begin
								n_q <= '0;
								mean_q <= '0;
								state_q <= S_DONE;
							end
							OP_INSIDE: state_q <= (int'(n_q) < MIN_POLY) ? S_DONE : S_IN_RD;
							OP_DIRECTION: state_q <= (int'(n_q) < MIN_POLY) ? S_DONE : S_DR_RD;
							default: state_q <= S_DONE;
						endcase
					end
				end

				// exact duplicate check, then append
				S_DUP: begin
					if (pv_q && vrd_q.x == px_q && vrd_q.y == py_q)
						flag_q <= 1'b1;
					if (scan_end) begin
						if (flag_q) begin
							state_q <= S_DONE;
						end else begin
							nn_q <= n_q + CW'(1);
							if (n_q == '0) begin
								n_q <= CW'(1);
								state_q <= S_MEAN_MUL;
							end else begin
								i_q <= '0;
								sx_q <= '0;
								sy_q <= '0;
								state_q <= S_SUM;
							end
						end
					end
				end

				S_SUM: begin
					if (pv_q) begin
						sx_q <= sx_q + SXW'(vrd_q.x);
						sy_q <= sy_q + SXW'(vrd_q.y);
					end
					if (scan_end) begin
						i_q <= '0;
						state_q <= S_ANG_RD;
					end
				end

				S_ANG_RD: state_q <= S_ANG_MUL;

				// offset from centroid scaled by n, so it stays exact
				S_ANG_MUL: begin
					cx_q <= DW'(n_sgn) * DW'(vrd_q.x) - DW'(sx_q);
					cy_q <= DW'(n_sgn) * DW'(vrd_q.y) - DW'(sy_q);
					state_q <= S_CRD_GO;
				end

				S_CRD_GO: state_q <= S_CRD_WT;

				S_CRD_WT: begin
					if (crd_done) begin
						if (op_q == OP_DIRECTION) begin
							if (first_q) begin
								a1_q <= a2;
								first_q <= 1'b0;
								state_q <= S_DR_RD;
							end else begin
								flag_q <= flag_q | hit;
								a1_q <= a2;
								if (i_q + CW'(1) >= n_q) begin
									inw_q <= flag_q | hit;
									state_q <= S_DONE;
								end else begin
									i_q <= i_q + CW'(1);
									state_q <= S_DR_RD;
								end
							end
						end else if (i_q + CW'(1) < nn_q) begin
							i_q <= i_q + CW'(1);
							state_q <= S_ANG_RD;
						end else begin
							k_q <= '0;
							have_prev_q <= 1'b0;
							found_q <= 1'b0;
							i_q <= '0;
							pv_q <= 1'b0;
							state_q <= S_SEL_SCAN;
						end
					end
				end

				S_SEL_SCAN: begin
					if (pv_q && cand) begin
						best_ang_q <= ard_q;
						best_idx_q <= pi_q;
						found_q <= 1'b1;
					end
					if (scan_end) begin
						if (found_q) begin
							state_q <= S_SEL_FETCH;
						end else begin
							i_q <= '0;
							state_q <= S_COPY;
						end
					end
				end

				S_SEL_FETCH: state_q <= S_SEL_PUT;

				S_SEL_PUT: begin
					prev_ang_q <= best_ang_q;
					have_prev_q <= 1'b1;
					k_q <= k_q + CW'(1);
					found_q <= 1'b0;
					i_q <= '0;
					state_q <= S_SEL_SCAN;
				end

				S_COPY: begin
					if (scan_end) begin
						n_q <= k_q;
						state_q <= S_MEAN_MUL;
					end
				end

				S_MEAN_MUL: begin
					num_q <= mnum;
					state_q <= S_DIV_GO;
				end

				S_DIV_GO: state_q <= S_DIV_WT;

				S_DIV_WT: begin
					if (div_done) begin
						mean_q <= 24'(qsat);
						ok_q <= 1'b1;
						state_q <= S_DONE;
					end
				end

				S_RMV: begin
					if (scan_end) begin
						n_q <= n_q - CW'(1);
						ok_q <= 1'b1;
						state_q <= S_DONE;
					end
				end

				S_IN_RD: state_q <= S_IN_EDGE;

				S_IN_EDGE: begin
					p1_q <= vrd_q;
					if (first_q) begin
						first_q <= 1'b0;
						state_q <= S_IN_RD;
					end else if (!e_flat && e_span) begin
						t1a_q <= xa - 17'(px_q);
						dyd_q <= yb - ya;
						t2a_q <= xb - xa;
						t2b_q <= 17'(py_q) - ya;
						state_q <= S_IN_M1;
					end else if (i_q + CW'(1) >= n_q) begin
						ins_q <= flag_q;
						state_q <= S_DONE;
					end else begin
						i_q <= i_q + CW'(1);
						state_q <= S_IN_RD;
					end
				end

				S_IN_M1: begin
					prod1_q <= mp;
					state_q <= S_IN_M2;
				end

				S_IN_M2: begin
					prod2_q <= mp;
					state_q <= S_IN_CMP;
				end

				S_IN_CMP: begin
					flag_q <= odd_n;
					if (i_q + CW'(1) >= n_q) begin
						ins_q <= odd_n;
						state_q <= S_DONE;
					end else begin
						i_q <= i_q + CW'(1);
						state_q <= S_IN_RD;
					end
				end

				S_DR_RD: state_q <= S_DR_LD;

				S_DR_LD: begin
					cx_q <= DW'(vrd_q.x) - DW'(px_q);
					cy_q <= DW'(vrd_q.y) - DW'(py_q);
					state_q <= S_CRD_GO;
				end

				S_DONE: begin
					res_q.ok <= ok_q;
					res_q.inside_res <= ins_q;
					res_q.inwards <= inw_q;
					res_q.vertex_count <= 7'(n_q);
					res_q.z_average <= mean_q;
					res_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

endmodule

// ----- hdl/pbs_cordic.sv -----
// iterative cordic vectoring unit giving the 16-bit binary angle of a vector
// one rotation step per cycle; uses pbs_pkg for the arctangent table

module pbs_cordic import pbs_pkg::*; #(
	parameter int DW = 25,
	parameter int STEPS = CORDIC_STEPS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [DW-1:0] dx,
	input  logic signed [DW-1:0] dy,
	output logic                 done,
	output logic [15:0]          angle
);

	localparam int IW = DW + 2;
	localparam int SW = $clog2(STEPS + 1);

	logic signed [IW-1:0] x_q, y_q, xs, ys;
	logic [15:0] acc_q;
	logic [SW-1:0] step_q;
	logic busy_q, done_q;

	assign xs = x_q >>> step_q;
	assign ys = y_q >>> step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
			acc_q <= '0;
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				if (dx < 0) begin
					x_q <= -(IW'(dx));
					y_q <= -(IW'(dy));
					acc_q <= HALF_TURN;
				end else begin
					x_q <= IW'(dx);
					y_q <= IW'(dy);
					acc_q <= '0;
				end
			end else if (busy_q) begin
				if (y_q == '0 || step_q == SW'(STEPS)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + SW'(1);
					if (y_q > 0) begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						acc_q <= acc_q + atan_ent(5'(step_q));
					end else begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						acc_q <= acc_q - atan_ent(5'(step_q));
					end
				end
			end
		end
	end

	assign done = done_q;
	assign angle = acc_q;

endmodule

// ----- hdl/pbs_div.sv -----
// iterative restoring divider, signed numerator over unsigned divisor
// one quotient bit per cycle, truncates toward zero; no dependencies

module pbs_div #(
	parameter int NW = 33,
	parameter int DVW = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [NW-1:0] num,
	input  logic [DVW-1:0]       den,
	output logic                 done,
	output logic signed [NW-1:0] quo
);

	localparam int KW = $clog2(NW + 1);

	logic [NW-1:0] q_q;
	logic [DVW:0] r_q, r_sh, den_x;
	logic [DVW-1:0] den_q;
	logic [KW-1:0] cnt_q;
	logic neg_q, busy_q, done_q, ge;

	assign den_x = {1'b0, den_q};
	assign r_sh = {r_q[DVW-1:0], q_q[NW-1]};
	assign ge = r_sh >= den_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q <= '0;
			r_q <= '0;
			den_q <= '0;
			cnt_q <= '0;
			neg_q <= 1'b0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				q_q <= (num < 0) ? NW'(-num) : NW'(num);
				neg_q <= num < 0;
				den_q <= den;
				r_q <= '0;
				cnt_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				q_q <= {q_q[NW-2:0], ge};
				r_q <= ge ? (r_sh - den_x) : r_sh;
				cnt_q <= cnt_q + KW'(1);
				if (cnt_q == KW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo = neg_q ? -signed'(q_q) : signed'(q_q);

endmodule

// ----- test/tb_polygon_boundary_store.sv -----
// self-checking testbench for polygon_boundary_store: random command gaps, random result stalls
// depends on pbs_pkg and the polygon_boundary_store rtl; predicts every result itself
`timescale 1ns / 1ps

module tb_polygon_boundary_store;
	import pbs_pkg::*;

	localparam int NPTS = 64;
	localparam int STEPS = 14;
	localparam int IDLE_LIMIT = 40000;
	localparam int TAIL_CYCLES = 200;
	localparam int HOLD_CYCLES = 400;
	localparam int ATAN_TAB [STEPS] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20,
		10, 5, 3, 1};
	localparam logic [2:0] OP_UNDEF_LO = 3'd5;
	localparam logic [2:0] OP_UNDEF_MID = 3'd6;
	localparam logic [2:0] OP_UNDEF_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd = '0;
	logic res_valid;
	logic res_stall = 1'b1;
	rsp_t res;
	bit hold_req = 0;
	int idle_cycles = 0;
	int n_sent = 0;

	always #5 clk = ~clk;

	polygon_boundary_store DUT (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

	// shadow copy of the boundary and the queue of results still owed
	class boundary_scoreboard;
		int vx [NPTS];
		int vy [NPTS];
		int ang [NPTS];
		int count;
		int mean;
		rsp_t owed [$];
		int errors;

		function new();
			count = 0;
			mean = 0;
			errors = 0;
		endfunction

		// cordic vectoring angle, 16-bit binary angle
		function int bin_angle(longint dx, longint dy);
			longint x, y, xs, ys;
			int unsigned acc;
			logic signed [15:0] a16;
			x = dx;
			y = dy;
			acc = 0;
			if (x == 0 && y == 0)
				return 0;
			if (x < 0) begin
				x = -x;
				y = -y;
				acc = 32768;
			end
			for (int i = 0; i < STEPS; i++) begin
				if (y == 0)
					break;
				xs = x >>> i;
				ys = y >>> i;
				if (y > 0) begin
					x += ys;
					y -= xs;
					acc += ATAN_TAB[i];
				end else begin
					x -= ys;
					y += xs;
					acc -= ATAN_TAB[i];
				end
			end
			a16 = acc[15:0];
			return a16;
		endfunction

		// angles about the centroid, drop earlier of equal angles, insertion sort
		function void resort(int n);
			longint sx, sy;
			int k, j, ax, ay, aa;
			bit keep;
			sx = 0;
			sy = 0;
			k = 0;
			if (n <= 1) begin
				if (n == 1)
					ang[0] = 0;
				count = n;
				return;
			end
			for (int i = 0; i < n; i++) begin
				sx += vx[i];
				sy += vy[i];
			end
			for (int i = 0; i < n; i++)
				ang[i] = bin_angle(longint'(n) * vx[i] - sx, longint'(n) * vy[i] - sy);
			for (int i = 0; i < n; i++) begin
				keep = 1;
				for (int q = i + 1; q < n; q++)
					if (ang[q] == ang[i])
						keep = 0;
				if (keep) begin
					vx[k] = vx[i];
					vy[k] = vy[i];
					ang[k] = ang[i];
					k++;
				end
			end
			for (int i = 1; i < k; i++) begin
				ax = vx[i];
				ay = vy[i];
				aa = ang[i];
				j = i;
				while (j > 0 && ang[j - 1] > aa) begin
					vx[j] = vx[j - 1];
					vy[j] = vy[j - 1];
					ang[j] = ang[j - 1];
					j--;
				end
				vx[j] = ax;
				vy[j] = ay;
				ang[j] = aa;
			end
			count = k;
		endfunction

		function bit add_vertex(int x, int y, int z);
			longint num, q;
			if (count >= NPTS)
				return 0;
			for (int i = 0; i < count; i++)
				if (vx[i] == x && vy[i] == y)
					return 0;
			vx[count] = x;
			vy[count] = y;
			resort(count + 1);
			num = longint'(mean) * (count - 1) + longint'(z) * 256;
			q = num / count;
			if (q > 8388607)
				q = 8388607;
			if (q < -8388608)
				q = -8388608;
			mean = int'(q);
			return 1;
		endfunction

		// even-odd crossing count, half-open in y
		function bit is_inside(int px, int py);
			longint x1, y1, x2, y2, t;
			bit odd;
			int p;
			odd = 0;
			if (count < MIN_POLY)
				return 0;
			for (int i = 0; i < count; i++) begin
				p = (i == 0) ? count - 1 : i - 1;
				x1 = vx[p];
				y1 = vy[p];
				x2 = vx[i];
				y2 = vy[i];
				if (y1 == y2)
					continue;
				if (y2 < y1) begin
					t = x1; x1 = x2; x2 = t;
					t = y1; y1 = y2; y2 = t;
				end
				if (py >= y1 && py < y2)
					if (x1 * (y2 - y1) + (x2 - x1) * (py - y1) <= longint'(px) * (y2 - y1))
						odd = !odd;
			end
			return odd;
		endfunction

		function bit points_inwards(int px, int py, int h);
			int a1, a2, s, l;
			if (count < MIN_POLY)
				return 0;
			a1 = bin_angle(longint'(vx[count - 1]) - px, longint'(vy[count - 1]) - py);
			for (int i = 0; i < count; i++) begin
				a2 = bin_angle(longint'(vx[i]) - px, longint'(vy[i]) - py);
				s = (a1 < a2) ? a1 : a2;
				l = (a1 < a2) ? a2 : a1;
				if (l - s < 32768) begin
					if (h >= s && h <= l)
						return 1;
				end else begin
					if (h <= s || h >= l)
						return 1;
				end
				a1 = a2;
			end
			return 0;
		endfunction

		// accepted command: advance the shadow and queue its result
		function void note_cmd(cmd_t c);
			rsp_t r;
			r = '0;
			case (c.operation)
				OP_ADD: begin
					r.ok = add_vertex(c.px, c.py, c.pz);
				end
				OP_REMOVE: begin
					if (c.index < count) begin
						for (int i = c.index; i + 1 < count; i++) begin
							vx[i] = vx[i + 1];
							vy[i] = vy[i + 1];
							ang[i] = ang[i + 1];
						end
						count--;
						r.ok = 1;
					end
				end
				OP_CLEAR: begin
					count = 0;
					mean = 0;
				end
				OP_INSIDE: begin
					r.inside_res = is_inside(c.px, c.py);
				end
				OP_DIRECTION: begin
					r.inwards = points_inwards(c.px, c.py, c.heading);
				end
				default: ;
			endcase
			r.vertex_count = count[6:0];
			r.z_average = mean[23:0];
			owed.push_back(r);
		endfunction

		task report(string what, longint got, longint want);
			$display("mismatch on %s: got %0d, expected %0d (at %0t)", what, got, want, $realtime);
			errors++;
		endtask

		task check_rsp(rsp_t got);
			rsp_t want;
			if (owed.size() == 0) begin
				report("unexpected result", 1, 0);
				return;
			end
			want = owed.pop_front();
			if (got.ok !== want.ok)
				report("ok", got.ok, want.ok);
			if (got.inside_res !== want.inside_res)
				report("inside_res", got.inside_res, want.inside_res);
			if (got.inwards !== want.inwards)
				report("inwards", got.inwards, want.inwards);
			if (got.vertex_count !== want.vertex_count)
				report("vertex_count", got.vertex_count, want.vertex_count);
			if (got.z_average !== want.z_average)
				report("z_average", got.z_average, want.z_average);
		endtask
	endclass

	boundary_scoreboard sb = new();

	// one command transaction after a random idle gap
	task send(cmd_t c);
		int gap;
		gap = $urandom_range(0, 13);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		repeat (gap) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		sb.note_cmd(c);
		n_sent++;
	endtask

	task send_op(logic [2:0] op, int x, int y, int z, int idx, int h);
		cmd_t c;
		c.operation = op;
		c.px = x[15:0];
		c.py = y[15:0];
		c.pz = z[15:0];
		c.index = idx[5:0];
		c.heading = h[15:0];
		send(c);
	endtask

	// every field random apart from the operation
	task send_rand(logic [2:0] op, bit near);
		cmd_t c;
		logic [95:0] rbits;
		rbits = {$urandom, $urandom, $urandom};
		c = rbits[$bits(cmd_t)-1:0];
		c.operation = op;
		if (near) begin
			c.px = 16'($urandom_range(0, 128) - 64);
			c.py = 16'($urandom_range(0, 128) - 64);
		end
		send(c);
	endtask

	// idle the command side and wait for every owed result
	task wait_drained();
		cmd_valid <= 1'b0;
		while (sb.owed.size() != 0)
			@(posedge clk);
	endtask

	// receiver: random stall per result, one long hold-off on request
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			g = $urandom_range(0, 13);
			if ($urandom_range(0, 3) == 0)
				g = 0;
			if (hold_req) begin
				g = HOLD_CYCLES;
				hold_req = 0;
			end
			repeat (g) begin
				res_stall <= 1'b1;
				@(posedge clk);
			end
			res_stall <= 1'b0;
			@(posedge clk);
			while (!res_valid)
				@(posedge clk);
			sb.check_rsp(res);
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("polygon_boundary_store test failed");
			$finish;
		end
	end

	initial begin
		bit near;
		int nadd, nq, sel;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty store, extremes, duplicate, collision, bad index, undefined codes
		send_op(OP_INSIDE, 0, 0, 0, 0, 0);
		send_op(OP_DIRECTION, 0, 0, 0, 0, 0);
		send_op(OP_REMOVE, 0, 0, 0, 0, 0);
		send_op(OP_ADD, 32767, 32767, 32767, 0, 0);
		send_op(OP_ADD, -32768, -32768, -32768, 0, 0);
		send_op(OP_ADD, -32768, -32768, 5, 0, 0);
		send_op(OP_INSIDE, 0, 0, 0, 0, 0);
		send_op(OP_ADD, 32767, -32768, 0, 0, 0);
		send_op(OP_ADD, -32768, 32767, -32768, 0, 0);
		send_op(OP_INSIDE, 0, 0, 0, 0, 0);
		send_op(OP_INSIDE, -32768, -32768, 0, 0, 0);
		send_op(OP_DIRECTION, 0, 0, 0, 0, -32768);
		send_op(OP_DIRECTION, 32767, 32767, 0, 0, 32767);
		send_op(OP_REMOVE, 0, 0, 0, 63, 0);
		send_op(OP_REMOVE, 0, 0, 0, 0, 0);
		send_op(OP_UNDEF_LO, 1, 2, 3, 4, 5);
		send_op(OP_UNDEF_MID, 0, 0, 0, 0, 0);
		send_op(OP_UNDEF_HI, -1, -1, -1, 63, -1);
		send_op(OP_CLEAR, 0, 0, 0, 0, 0);
		// collinear adds where the midpoint lands on the centroid and collides
		send_op(OP_ADD, 0, 0, 100, 0, 0);
		send_op(OP_ADD, 20, 0, -100, 0, 0);
		send_op(OP_ADD, 10, 0, 7, 0, 0);
		send_op(OP_ADD, 10, 10, 7, 0, 0);
		send_op(OP_INSIDE, 10, 0, 0, 0, 0);
		send_op(OP_DIRECTION, 10, 5, 0, 0, 16384);

		// sender waits out every owed result
		wait_drained();

		// one full store: fill past capacity, refused adds, removes at high indexes
		send_op(OP_CLEAR, 0, 0, 0, 0, 0);
		for (int i = 0; i < 70; i++)
			send_op(OP_ADD, $urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000,
				$urandom, 0, 0);
		send_rand(OP_INSIDE, 1);
		send_rand(OP_DIRECTION, 1);
		send_op(OP_REMOVE, 0, 0, 0, 63, 0);
		send_rand(OP_REMOVE, 0);

		// long receiver hold-off while commands keep coming
		hold_req = 1;
		for (int i = 0; i < 6; i++)
			send_rand(OP_REMOVE, 0);
		send_op(OP_CLEAR, 0, 0, 0, 0, 0);

		// random phases: build a small polygon, then query and edit it
		while (n_sent < 140) begin
			near = $urandom_range(0, 3) != 0;
			if ($urandom_range(0, 4) != 0)
				send_rand(OP_CLEAR, 0);
			nadd = $urandom_range(1, 8);
			for (int i = 0; i < nadd; i++)
				send_rand(OP_ADD, near);
			nq = $urandom_range(3, 8);
			for (int i = 0; i < nq; i++) begin
				sel = $urandom_range(0, 19);
				if (sel < 7)
					send_rand(OP_INSIDE, near);
				else if (sel < 14)
					send_rand(OP_DIRECTION, near);
				else if (sel < 17)
					send_rand(OP_REMOVE, 0);
				else if (sel < 18)
					send_rand(OP_ADD, near);
				else
					send_rand(3'($urandom_range(5, 7)), 0);
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.owed.size() == 0)
			$display("polygon_boundary_store test passed");
		else
			$display("polygon_boundary_store test failed");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/pbs_pkg.sv
hdl/pbs_cordic.sv
hdl/pbs_div.sv
hdl/polygon_boundary_store.sv
test/tb_polygon_boundary_store.sv
